[rtl/core/brb_pkg.sv]
// ----------------------------------------------------------------------------
// brb_pkg: shared types and constants for the byte ring buffer
// Field widths, operation codes and configuration register indexes.
// ----------------------------------------------------------------------------
package brb_pkg;

  localparam int FUNC_W      = 3;
  localparam int DATA_W      = 8;
  localparam int OFFSET_W    = 11;
  localparam int RING_SIZE_W = 11;
  localparam int FILL_W      = 10;
  localparam int CFG_IDX_W   = 1;
  localparam int DIV_CNT_W   = $clog2(OFFSET_W);

  typedef enum logic [FUNC_W-1:0] {
    FN_WRITE     = 3'd0,
    FN_READ      = 3'd1,
    FN_PEEK_RD   = 3'd2,
    FN_PEEK_WR   = 3'd3,
    FN_MOVE_RD   = 3'd4,
    FN_MOVE_WR   = 3'd5,
    FN_DISCARD   = 3'd6,
    FN_RESET_PTR = 3'd7
  } func_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RING_SIZE   = 1'd0,
    REG_DROP_OLDEST = 1'd1
  } cfg_reg_e;

endpackage

[rtl/core/byte_ring_buffer_with_overflow_policy.sv]
// ----------------------------------------------------------------------------
// byte_ring_buffer_with_overflow_policy: byte ring with drop-oldest option
// Write, read, peek and pointer moves over a ring of configurable length,
// offsets reduced modulo the ring size by a shared subtract-compare unit.
// ----------------------------------------------------------------------------
//
//  channel  | handshake              | word
//  ---------+------------------------+----------------------------------------
//  command  | start_i, busy_o        | func_i, data_in_i, offset_i
//  result   | done_o (strobe)        | data_out_o, fill_count_o, is_empty_o,
//           |                        | overflowed_o
//  config   | cfg_valid_i, cfg_ready_o | cfg_index_i, cfg_data_i
//
//  A word is taken when start_i is high and busy_o low; done_o rises for one
//  cycle with the result. Writes, discards and pointer resets go straight to
//  the finish step; reads wait for the registered RAM read. Moves and peeks
//  run the 11-step restoring remainder loop (one bit of the offset per
//  cycle), then the adjust and add steps and, for peeks, the registered RAM
//  read. busy_o falls as done_o rises; no new word is taken before that.
//  After reset the store is swept to zero, one entry a cycle, with busy_o
//  high. Config writes are taken at any time (cfg_ready_o is tied high). The
//  result side cannot stall.
//
module byte_ring_buffer_with_overflow_policy #(
  parameter int DEPTH = 1024
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // command
  input  logic                           start_i,
  output logic                           busy_o,
  input  logic [brb_pkg::FUNC_W-1:0]     func_i,
  input  logic [brb_pkg::DATA_W-1:0]     data_in_i,
  input  logic signed [brb_pkg::OFFSET_W-1:0] offset_i,
  // result
  output logic                           done_o,
  output logic [brb_pkg::DATA_W-1:0]     data_out_o,
  output logic [brb_pkg::FILL_W-1:0]     fill_count_o,
  output logic                           is_empty_o,
  output logic                           overflowed_o,
  // configuration
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [brb_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [brb_pkg::RING_SIZE_W-1:0] cfg_data_i
);

  import brb_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int SW = $clog2(DEPTH + 1);
  localparam int CW = (SW > RING_SIZE_W) ? SW : RING_SIZE_W;
  localparam int RW = CW + 1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV,
    ST_ADJ,
    ST_ADD,
    ST_RDWAIT,
    ST_FIN
  } state_e;

  // next pointer with wrap at the ring end
  function automatic logic [AW-1:0] inc_wrap(input logic [AW-1:0] p,
                                             input logic [SW-1:0] s);
    logic [AW-1:0] res;
    if (SW'(p) == s - SW'(1)) begin
      res = '0;
    end else begin
      res = p + AW'(1);
    end
    return res;
  endfunction

  state_e               state_q;
  logic [AW-1:0]        clr_cnt_q;
  logic [RING_SIZE_W-1:0] ring_size_q;
  logic                 drop_oldest_q;
  logic [AW-1:0]        rd_q, wr_q;
  func_e                func_q;
  logic [OFFSET_W-1:0]  mag_q;
  logic                 neg_q;
  logic [RW-1:0]        rem_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [DATA_W-1:0]    dout_q;
  logic                 ovf_q;

  // result registers
  logic                 done_q;
  logic [DATA_W-1:0]    data_out_q;
  logic [FILL_W-1:0]    fill_q;
  logic                 empty_q;
  logic                 ovf_out_q;

  // effective ring size, clamped to 2..DEPTH
  logic [CW-1:0] size_ext;
  logic [SW-1:0] s_eff;
  logic [RW-1:0] s_rw;

  always_comb begin
    size_ext = CW'(ring_size_q);
    if (size_ext < CW'(2)) begin
      s_eff = SW'(2);
    end else if (size_ext > CW'(DEPTH)) begin
      s_eff = SW'(DEPTH);
    end else begin
      s_eff = SW'(size_ext);
    end
  end

  assign s_rw = RW'(s_eff);

  // pointers forced inside the ring
  logic [AW-1:0] r_eff, w_eff;
  assign r_eff = (SW'(rd_q) >= s_eff) ? '0 : rd_q;
  assign w_eff = (SW'(wr_q) >= s_eff) ? '0 : wr_q;

  logic  accept;
  func_e func_in;
  assign accept  = start_i && (state_q == ST_IDLE);
  assign func_in = func_e'(func_i);

  // shared subtract-compare unit: remainder steps and final wrap
  logic [RW-1:0] rem_sh, base_rw, sum_rw, unit_a, unit_res;
  logic          unit_ge;
  logic [AW-1:0] tgt;

  assign rem_sh  = {rem_q[RW-2:0], mag_q[OFFSET_W-1]};
  assign base_rw = ((func_q == FN_PEEK_RD) || (func_q == FN_MOVE_RD)) ?
                   RW'(rd_q) : RW'(wr_q);
  assign sum_rw  = base_rw + rem_q;
  assign unit_a  = (state_q == ST_DIV) ? rem_sh : sum_rw;
  assign unit_ge = (unit_a >= s_rw);
  assign unit_res = unit_ge ? (unit_a - s_rw) : unit_a;
  assign tgt     = unit_res[AW-1:0];

  // write path outcome
  logic [AW-1:0] nw, nr_drop;
  logic          full_hit;
  assign nw       = inc_wrap(w_eff, s_eff);
  assign nr_drop  = inc_wrap(r_eff, s_eff);
  assign full_hit = (nw == r_eff);

  // fill count after the operation
  logic [RW-1:0] fill_rw;
  assign fill_rw = RW'(wr_q) - RW'(rd_q) + ((wr_q < rd_q) ? s_rw : '0);

  // RAM ports
  logic              ram_we;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [DATA_W-1:0] ram_wdata, ram_rdata;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = w_eff;
    ram_wdata = data_in_i;
    if (state_q == ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_cnt_q;
      ram_wdata = '0;
    end else if (accept && (func_in == FN_WRITE)) begin
      ram_we = 1'b1;
    end
    ram_raddr = (state_q == ST_ADD) ? tgt : r_eff;
  end

  brb_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_CLEAR;
      clr_cnt_q     <= '0;
      ring_size_q   <= RING_SIZE_W'(1024);
      drop_oldest_q <= 1'b0;
      rd_q          <= '0;
      wr_q          <= '0;
      func_q        <= FN_WRITE;
      mag_q         <= '0;
      neg_q         <= 1'b0;
      rem_q         <= '0;
      cnt_q         <= '0;
      dout_q        <= '0;
      ovf_q         <= 1'b0;
      done_q        <= 1'b0;
      data_out_q    <= '0;
      fill_q        <= '0;
      empty_q       <= 1'b0;
      ovf_out_q     <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        ST_CLEAR: begin
          clr_cnt_q <= clr_cnt_q + AW'(1);
          if (clr_cnt_q == AW'(DEPTH - 1)) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (start_i) begin
            func_q <= func_in;
            dout_q <= '0;
            ovf_q  <= 1'b0;
            rd_q   <= r_eff;
            wr_q   <= w_eff;
            // magnitude of the signed offset, 11 bits unsigned
            mag_q  <= offset_i[OFFSET_W-1] ? (~offset_i + OFFSET_W'(1)) : offset_i;
            neg_q  <= offset_i[OFFSET_W-1];
            rem_q  <= '0;
            cnt_q  <= DIV_CNT_W'(OFFSET_W - 1);
            unique case (func_in)
              FN_WRITE: begin
                wr_q  <= nw;
                ovf_q <= full_hit;
                if (full_hit && drop_oldest_q) begin
                  rd_q <= nr_drop;
                end
                state_q <= ST_FIN;
              end
              FN_READ: begin
                state_q <= ST_RDWAIT;
              end
              FN_PEEK_RD, FN_PEEK_WR, FN_MOVE_RD, FN_MOVE_WR: begin
                state_q <= ST_DIV;
              end
              FN_DISCARD: begin
                rd_q    <= w_eff;
                state_q <= ST_FIN;
              end
              FN_RESET_PTR: begin
                rd_q    <= '0;
                wr_q    <= '0;
                state_q <= ST_FIN;
              end
              default: begin
                state_q <= ST_FIN;
              end
            endcase
          end
        end
        ST_DIV: begin
          // one restoring step per cycle, offset MSB first
          rem_q <= unit_res;
          mag_q <= {mag_q[OFFSET_W-2:0], 1'b0};
          cnt_q <= cnt_q - DIV_CNT_W'(1);
          if (cnt_q == '0) begin
            state_q <= ST_ADJ;
          end
        end
        ST_ADJ: begin
          // negative offset: step back by the remainder
          if (neg_q && (rem_q != '0)) begin
            rem_q <= s_rw - rem_q;
          end
          state_q <= ST_ADD;
        end
        ST_ADD: begin
          priority case (func_q)
            FN_MOVE_RD: begin
              rd_q    <= tgt;
              state_q <= ST_FIN;
            end
            FN_MOVE_WR: begin
              wr_q    <= tgt;
              state_q <= ST_FIN;
            end
            default: begin
              state_q <= ST_RDWAIT;
            end
          endcase
        end
        ST_RDWAIT: begin
          dout_q <= ram_rdata;
          if ((func_q == FN_READ) && (rd_q != wr_q)) begin
            rd_q <= inc_wrap(rd_q, s_eff);
          end
          state_q <= ST_FIN;
        end
        ST_FIN: begin
          done_q     <= 1'b1;
          data_out_q <= dout_q;
          fill_q     <= fill_rw[FILL_W-1:0];
          empty_q    <= (rd_q == wr_q);
          ovf_out_q  <= ovf_q;
          state_q    <= ST_IDLE;
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase

      // config write; ring size change homes both pointers
      if (cfg_valid_i) begin
        unique case (cfg_reg_e'(cfg_index_i))
          REG_RING_SIZE: begin
            ring_size_q <= cfg_data_i;
            rd_q        <= '0;
            wr_q        <= '0;
          end
          REG_DROP_OLDEST: begin
            drop_oldest_q <= cfg_data_i[0];
          end
          default: begin
            drop_oldest_q <= drop_oldest_q;
          end
        endcase
      end
    end
  end

  assign busy_o       = (state_q != ST_IDLE);
  assign cfg_ready_o  = 1'b1;
  assign done_o       = done_q;
  assign data_out_o   = data_out_q;
  assign fill_count_o = fill_q;
  assign is_empty_o   = empty_q;
  assign overflowed_o = ovf_out_q;

`ifndef SYNTHESIS
  a_done_single : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q)
    else $error("result strobe held for more than one cycle");

  a_busy_after_start : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy_o)
    else $error("block not busy after taking a command");

  a_rd_in_ring : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> (SW'(rd_q) < s_eff) && (SW'(wr_q) < s_eff))
    else $error("pointer outside the ring while idle");

  a_empty_fill : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && empty_q) |-> (fill_q == '0))
    else $error("empty result with non-zero fill count");
`endif

endmodule

[rtl/core/brb_ram.sv]
// ----------------------------------------------------------------------------
// brb_ram: generic single-write, single-read RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module brb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
